FILE: hw/rtl/ifd_pkg.sv
// Package for the inertial frame decoder: field widths, codes and limits.
package ifd_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int CAP_DEPTH       = 29;
    localparam int CAP_IDX_W       = $clog2(CAP_DEPTH);
    localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
    localparam int LEN_W           = 7;
    localparam int TURN_CDEG       = 36000;

    localparam int IN_W   = 8;
    localparam int OUT_W  = 208;
    localparam int CFG_W  = 17;
    localparam int ADDR_W = 3;

    localparam logic [7:0] HDR_BYTE0   = 8'hAA;
    localparam logic [7:0] HDR_BYTE1   = 8'h55;
    localparam logic [7:0] POS_FLAG    = 8'h04;
    localparam logic [7:0] POS_STATUS  = 8'hF0;
    localparam logic [15:0] RUN_MAX    = 16'hFFFF;

    localparam logic signed [17:0] ANG_MAX = 18'sd50768;
    localparam logic signed [17:0] ANG_MIN = -18'sd50768;

    localparam logic [LEN_W-1:0] LEN_MIN_L0 = 7'd21;
    localparam logic [LEN_W-1:0] LEN_MIN_L1 = 7'd29;
    localparam logic [LEN_W-1:0] LEN_MIN_L2 = 7'd25;
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] LEN_RESET  = 7'd32;

    typedef enum logic [1:0] {
        FMT_LE16 = 2'd0,
        FMT_BE   = 2'd1,
        FMT_LE32 = 2'd2,
        FMT_ALT  = 2'd3
    } frame_fmt_t;

    typedef enum logic [1:0] {
        RES_OK     = 2'd0,
        RES_HEADER = 2'd1,
        RES_CSUM   = 2'd2,
        RES_UNUSED = 2'd3
    } result_code_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_FRAME_FORMAT   = 3'd0,
        REG_FRAME_LENGTH   = 3'd1,
        REG_PITCH_OFFSET   = 3'd2,
        REG_ROLL_OFFSET    = 3'd3,
        REG_HEADING_OFFSET = 3'd4,
        REG_SPARE5         = 3'd5,
        REG_SPARE6         = 3'd6,
        REG_SPARE7         = 3'd7
    } reg_index_t;

endpackage

FILE: hw/rtl/inertial_frame_decoder.sv
// Inertial frame decoder: byte-serial header/checksum check and field decode.
// Throughput: one byte word per cycle; s_tready drops only while a finished
// frame waits behind a result word that the master side has not yet taken.
// The last frame byte is captured and the frame is marked pending; the fields
// are then decoded into the held registers and the result word is raised once
// any earlier word is taken. Reset clears position, sum, held values, the
// bad-frame run and the registers; the capture bytes are left unreset.
module inertial_frame_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ifd_pkg::IN_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                         s_tuser,   // [0] frame_start
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] unit_status, [24:8] pitch_cdeg, [41:25] roll_cdeg,
    // [57:42] heading_cdeg, [89:58] longitude_raw, [121:90] latitude_raw,
    // [138:122] height_m, [154:139] rate_x_raw, [170:155] rate_y_raw,
    // [186:171] rate_z_raw, [202:187] bad_frame_run, [207:203] zero
    output logic [ifd_pkg::OUT_W-1:0]    m_tdata,
    output logic [1:0]                   m_tuser,   // [1:0] result_code
    input  logic                         cfg_we,
    input  logic [ifd_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [ifd_pkg::CFG_W-1:0]    cfg_wdata
);
    import ifd_pkg::*;

    // Configuration registers.
    frame_fmt_t              fmt_reg;
    logic [LEN_W-1:0]        len_reg;
    logic signed [15:0]      pitch_ofs_reg;
    logic signed [15:0]      roll_ofs_reg;
    logic signed [16:0]      head_ofs_reg;

    // Byte-stage state.
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [7:0]              sum_reg, sum_next;
    logic                    hdr_reg, hdr_next;
    logic                    done_reg, done_next;
    logic [7:0]              cap_reg [CAP_DEPTH];
    logic                    pend_reg, pend_next;
    result_code_t            pend_code_reg, pend_code_next;

    // Held values; they are also the output payload.
    logic [7:0]              status_reg;
    logic signed [16:0]      pitch_reg, roll_reg, height_reg;
    logic [15:0]             heading_reg;
    logic [31:0]             lon_reg, lat_reg;
    logic [15:0]             rate_x_reg, rate_y_reg, rate_z_reg;
    logic [15:0]             run_reg;
    result_code_t            code_reg;
    logic                    m_tvalid_reg;

    logic                    accept;
    logic                    fire;
    logic                    frame_end;
    logic [POS_W-1:0]        pos_eff;
    logic [7:0]              sum_eff;
    logic                    done_eff;
    logic [LEN_W-1:0]        len_lo, len_clip, len_m1;
    logic [POS_W-1:0]        last_pos;
    logic                    cap_we;
    logic [CAP_IDX_W-1:0]    cap_idx;

    assign fire     = pend_reg && !(m_tvalid_reg && !m_tready);
    assign s_tready = !(pend_reg && m_tvalid_reg && !m_tready);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_LE16;
            len_reg       <= LEN_RESET;
            pitch_ofs_reg <= '0;
            roll_ofs_reg  <= '0;
            head_ofs_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_FRAME_FORMAT:   fmt_reg       <= frame_fmt_t'(cfg_wdata[1:0]);
                REG_FRAME_LENGTH:   len_reg       <= cfg_wdata[LEN_W-1:0];
                REG_PITCH_OFFSET:   pitch_ofs_reg <= cfg_wdata[15:0];
                REG_ROLL_OFFSET:    roll_ofs_reg  <= cfg_wdata[15:0];
                REG_HEADING_OFFSET: head_ofs_reg  <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // Effective last byte position for the selected layout.
    always_comb
    begin
        unique case (fmt_reg)
            FMT_BE:   len_lo = LEN_MIN_L1;
            FMT_LE32: len_lo = LEN_MIN_L2;
            default:  len_lo = LEN_MIN_L0;
        endcase
        len_clip = (len_reg < len_lo) ? len_lo : len_reg;
        if (len_clip > LEN_MAX)
        begin
            len_clip = LEN_MAX;
        end
        len_m1   = len_clip - LEN_W'(1);
        last_pos = len_m1[POS_W-1:0];
    end

    // Byte stage: position, running sum, header check and capture.
    always_comb
    begin
        pos_eff   = s_tuser ? '0 : pos_reg;
        sum_eff   = s_tuser ? '0 : sum_reg;
        done_eff  = s_tuser ? 1'b0 : done_reg;
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        hdr_next  = hdr_reg;
        done_next = done_reg;
        frame_end = 1'b0;
        cap_we    = 1'b0;
        cap_idx   = pos_eff[CAP_IDX_W-1:0];
        pend_code_next = pend_code_reg;
        if (accept)
        begin
            pos_next  = pos_eff;
            sum_next  = sum_eff;
            done_next = done_eff;
            if (!done_eff)
            begin
                cap_we = (pos_eff < POS_W'(CAP_DEPTH));
                if (pos_eff == POS_W'(0))
                begin
                    hdr_next = (s_tdata == HDR_BYTE0);
                end
                else if (pos_eff == POS_W'(1))
                begin
                    hdr_next = hdr_reg && (s_tdata == HDR_BYTE1);
                end
                if (pos_eff < last_pos)
                begin
                    sum_next = sum_eff + s_tdata;
                    pos_next = pos_eff + POS_W'(1);
                end
                else
                begin
                    done_next = 1'b1;
                    frame_end = 1'b1;
                    priority if (!hdr_reg)
                    begin
                        pend_code_next = RES_HEADER;
                    end
                    else if ((fmt_reg == FMT_BE) ? (sum_eff != s_tdata)
                                                 : (sum_eff + s_tdata != 8'd0))
                    begin
                        pend_code_next = RES_CSUM;
                    end
                    else
                    begin
                        pend_code_next = RES_OK;
                    end
                end
            end
        end
        pend_next = (pend_reg && !fire) || frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            hdr_reg       <= 1'b0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_code_reg <= RES_OK;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            hdr_reg       <= hdr_next;
            done_reg      <= done_next;
            pend_reg      <= pend_next;
            pend_code_reg <= pend_code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_we)
        begin
            cap_reg[cap_idx] <= s_tdata;
        end
    end

    // Decode stage: fields come from the capture bytes of the finished frame.
    logic [15:0]             raw_pitch, raw_roll, raw_head;
    logic signed [17:0]      pitch_sum, roll_sum;
    logic signed [18:0]      head_sum, head_wrap;
    logic signed [16:0]      pitch_sat, roll_sat;
    logic [31:0]             lon_dec, lat_dec;
    logic signed [16:0]      height_dec;
    logic                    be_pos_upd;
    logic [15:0]             run_inc;

    always_comb
    begin
        if (fmt_reg == FMT_BE)
        begin
            raw_pitch = {cap_reg[23], cap_reg[24]};
            raw_roll  = {cap_reg[25], cap_reg[26]};
            raw_head  = {cap_reg[27], cap_reg[28]};
            pitch_sum = {{2{pitch_ofs_reg[15]}}, pitch_ofs_reg}
                      + {{2{raw_pitch[15]}}, raw_pitch};
            roll_sum  = {{2{roll_ofs_reg[15]}}, roll_ofs_reg}
                      + {{2{raw_roll[15]}}, raw_roll};
            head_sum  = {{2{head_ofs_reg[16]}}, head_ofs_reg}
                      - {{3{raw_head[15]}}, raw_head};
        end
        else
        begin
            raw_pitch = {cap_reg[10], cap_reg[9]};
            raw_roll  = {cap_reg[12], cap_reg[11]};
            raw_head  = {cap_reg[14], cap_reg[13]};
            pitch_sum = {{2{pitch_ofs_reg[15]}}, pitch_ofs_reg}
                      - {{2{raw_pitch[15]}}, raw_pitch};
            roll_sum  = {{2{roll_ofs_reg[15]}}, roll_ofs_reg}
                      - {{2{raw_roll[15]}}, raw_roll};
            head_sum  = {{2{head_ofs_reg[16]}}, head_ofs_reg}
                      + {3'b000, raw_head};
        end

        priority if (pitch_sum > ANG_MAX)      pitch_sat = ANG_MAX[16:0];
        else if (pitch_sum < ANG_MIN)          pitch_sat = ANG_MIN[16:0];
        else                                   pitch_sat = pitch_sum[16:0];
        priority if (roll_sum > ANG_MAX)       roll_sat = ANG_MAX[16:0];
        else if (roll_sum < ANG_MIN)           roll_sat = ANG_MIN[16:0];
        else                                   roll_sat = roll_sum[16:0];

        // The sum spans less than four turns on either side of zero, so a
        // fixed set of turn corrections covers every case.
        priority if (head_sum < -19'sd72000)   head_wrap = head_sum + 19'sd108000;
        else if (head_sum < -19'sd36000)       head_wrap = head_sum + 19'sd72000;
        else if (head_sum < 19'sd0)            head_wrap = head_sum + 19'sd36000;
        else if (head_sum < 19'sd36000)        head_wrap = head_sum;
        else if (head_sum < 19'sd72000)        head_wrap = head_sum - 19'sd36000;
        else if (head_sum < 19'sd108000)       head_wrap = head_sum - 19'sd72000;
        else                                   head_wrap = head_sum - 19'sd108000;

        unique case (fmt_reg)
            FMT_BE:
            begin
                lon_dec    = {cap_reg[12], cap_reg[13], cap_reg[14], cap_reg[15]};
                lat_dec    = {cap_reg[16], cap_reg[17], cap_reg[18], cap_reg[19]};
                height_dec = height_reg;
            end
            FMT_LE32:
            begin
                lon_dec    = {cap_reg[18], cap_reg[17], cap_reg[16], cap_reg[15]};
                lat_dec    = {cap_reg[22], cap_reg[21], cap_reg[20], cap_reg[19]};
                height_dec = {1'b0, cap_reg[24], cap_reg[23]};
            end
            default:
            begin
                lon_dec    = {{16{cap_reg[16][7]}}, cap_reg[16], cap_reg[15]};
                lat_dec    = {{16{cap_reg[18][7]}}, cap_reg[18], cap_reg[17]};
                height_dec = {cap_reg[20][7], cap_reg[20], cap_reg[19]};
            end
        endcase

        be_pos_upd = (cap_reg[11] & POS_FLAG) != 8'd0;
        run_inc    = (run_reg == RUN_MAX) ? run_reg : run_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg   <= '0;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            heading_reg  <= '0;
            lon_reg      <= '0;
            lat_reg      <= '0;
            height_reg   <= '0;
            rate_x_reg   <= '0;
            rate_y_reg   <= '0;
            rate_z_reg   <= '0;
            run_reg      <= '0;
            code_reg     <= RES_OK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                m_tvalid_reg <= 1'b1;
                code_reg     <= pend_code_reg;
                unique case (pend_code_reg)
                    RES_OK:
                    begin
                        pitch_reg   <= pitch_sat;
                        roll_reg    <= roll_sat;
                        heading_reg <= head_wrap[15:0];
                        if (fmt_reg == FMT_BE)
                        begin
                            if (be_pos_upd)
                            begin
                                lon_reg    <= lon_dec;
                                lat_reg    <= lat_dec;
                                status_reg <= POS_STATUS;
                            end
                        end
                        else
                        begin
                            run_reg    <= '0;
                            status_reg <= cap_reg[2];
                            lon_reg    <= lon_dec;
                            lat_reg    <= lat_dec;
                            height_reg <= height_dec;
                            rate_x_reg <= {cap_reg[6], cap_reg[5]};
                            rate_y_reg <= {cap_reg[4], cap_reg[3]};
                            rate_z_reg <= {cap_reg[8], cap_reg[7]};
                        end
                    end
                    RES_CSUM:
                    begin
                        // A layout 1 sum mismatch leaves the run alone.
                        if (fmt_reg != FMT_BE)
                        begin
                            run_reg <= run_inc;
                        end
                    end
                    default:
                    begin
                        run_reg <= run_inc;
                    end
                endcase
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = code_reg;
    assign m_tdata  = {5'b00000, run_reg, rate_z_reg, rate_y_reg, rate_x_reg,
                       height_reg, lat_reg, lon_reg, heading_reg, roll_reg,
                       pitch_reg, status_reg};

    // A finished frame always finds the decode stage empty.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |-> !pend_reg)
        else $error("frame ended while a decode was still pending");

    a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid_reg)
        else $error("decoded frame did not raise the result word");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < 16'(TURN_CDEG))
        else $error("held heading outside one turn");

    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(run_reg))
        else $error("bad-frame run changed without a finished frame");

endmodule

FILE: test/inertial_frame_decoder_tb.sv
// Testbench for the inertial frame decoder: directed and random frames checked by a predictor.
module inertial_frame_decoder_tb;

    import ifd_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_BYTES   = 400;
    localparam int RANDOM_REPORTS = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PLAN_ROWS      = 20;

    typedef enum logic [2:0] {
        SH_CLEAN,
        SH_NO_START,
        SH_BAD_HEADER,
        SH_BAD_SUM,
        SH_TRAILING,
        SH_RESTART,
        SH_LEN_CUT
    } frame_shape_t;

    // One directed frame: the settings it runs under, its shape and, where it
    // is obvious, the result code and bad-frame run it must end with.
    typedef struct packed {
        frame_fmt_t   fmt;
        logic [6:0]   len;
        int           pitch_adj;
        int           roll_adj;
        int           heading_adj;
        frame_shape_t shape;
        int           fill;
        bit           pos_flag;
        bit           typed;
        result_code_t code;
        logic [15:0]  run;
    } plan_row_t;

    typedef struct packed {
        result_code_t code;
        logic [7:0]   status;
        logic [16:0]  pitch;
        logic [16:0]  roll;
        logic [15:0]  heading;
        logic [31:0]  lon;
        logic [31:0]  lat;
        logic [16:0]  height;
        logic [15:0]  rate_x;
        logic [15:0]  rate_y;
        logic [15:0]  rate_z;
        logic [15:0]  run;
    } frame_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;    // [7:0] rx_byte
    logic                s_tuser = 1'b0;  // [0] frame_start
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [7:0] unit_status, [24:8] pitch_cdeg, [41:25] roll_cdeg,
    // [57:42] heading_cdeg, [89:58] longitude_raw, [121:90] latitude_raw,
    // [138:122] height_m, [154:139] rate_x_raw, [170:155] rate_y_raw,
    // [186:171] rate_z_raw, [202:187] bad_frame_run, [207:203] zero
    logic [OUT_W-1:0]    m_tdata;
    logic [1:0]          m_tuser;         // [1:0] result_code
    logic                cfg_we = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    inertial_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Decoder settings as the block holds them.
    frame_fmt_t  fmt_now = FMT_LE16;
    logic [6:0]  len_now = LEN_RESET;
    logic [15:0] pitch_trim = '0;
    logic [15:0] roll_trim = '0;
    logic [16:0] heading_trim = '0;

    // Frame parsing and held values.
    int          byte_idx = 0;
    logic [7:0]  sum_acc = '0;
    bit          hdr_ok = 1'b0;
    bit          frame_closed = 1'b0;
    logic [7:0]  cap [0:CAP_DEPTH-1];
    int          held_pitch = 0;
    int          held_roll = 0;
    int          held_heading = 0;
    int          held_height = 0;
    int          held_rate_x = 0;
    int          held_rate_y = 0;
    int          held_rate_z = 0;
    logic [31:0] held_lon = '0;
    logic [31:0] held_lat = '0;
    logic [7:0]  held_stat = '0;
    int          bad_run = 0;

    frame_report_t reports_due [$];
    int            fail_count = 0;
    int            live_bytes = 0;
    int            reports_seen = 0;
    int            cycles = 0;
    logic [1:0]    last_code = '0;
    logic [15:0]   last_run = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold_left = 0;

    logic [7:0] frame_buf [0:MAX_FRAME_BYTES-1];

    plan_row_t plan [PLAN_ROWS] = '{
        '{FMT_LE16, 7'd32,       0,      0,      0, SH_NO_START,   -1,   1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd32,       0,      0,      0, SH_CLEAN,      8'h00, 1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd21,       0,      0,      0, SH_CLEAN,      8'hFF, 1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd21,       0,      0,      0, SH_BAD_HEADER, -1,   1'b0, 1'b1,
          RES_HEADER, 16'd1},
        '{FMT_LE16, 7'd21,       0,      0,      0, SH_BAD_SUM,    -1,   1'b0, 1'b1,
          RES_CSUM, 16'd2},
        '{FMT_LE16, 7'd21,       0,      0,      0, SH_TRAILING,   -1,   1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE32, 7'd25,       0,      0,      0, SH_CLEAN,      8'hFF, 1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE32, 7'd64,       0,      0,      0, SH_CLEAN,      8'h80, 1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_BE,   7'd29,       0,      0,      0, SH_CLEAN,      8'h80, 1'b1, 1'b1,
          RES_OK, 16'd0},
        '{FMT_BE,   7'd29,       0,      0,      0, SH_BAD_HEADER, -1,   1'b1, 1'b1,
          RES_HEADER, 16'd1},
        '{FMT_BE,   7'd29,       0,      0,      0, SH_BAD_SUM,    -1,   1'b1, 1'b1,
          RES_CSUM, 16'd1},
        '{FMT_ALT,  7'd127,      0,      0,      0, SH_CLEAN,      -1,   1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd0,    32767,  32767,  65535, SH_CLEAN,      8'h80, 1'b0, 1'b0,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd32,  -32768, -32768, -65536, SH_CLEAN,      8'h7F, 1'b0, 1'b0,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd32,  -18000,  18000, -36000, SH_CLEAN,      -1,   1'b0, 1'b0,
          RES_OK, 16'd0},
        '{FMT_BE,   7'd29,   18000, -18000,  36000, SH_CLEAN,      -1,   1'b0, 1'b0,
          RES_OK, 16'd0},
        '{FMT_BE,   7'd40,       0,      0,  65535, SH_CLEAN,      -1,   1'b1, 1'b0,
          RES_OK, 16'd0},
        '{FMT_LE32, 7'd40,       0,      0,      0, SH_RESTART,    -1,   1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_LE16, 7'd40,       0,      0,      0, SH_LEN_CUT,    -1,   1'b0, 1'b1,
          RES_OK, 16'd0},
        '{FMT_ALT,  7'd21,       0,      0,      0, SH_BAD_SUM,    -1,   1'b0, 1'b1,
          RES_CSUM, 16'd1}
    };

    function automatic int frame_bytes(frame_fmt_t f, logic [6:0] l);
        int n;
        int lo;
        n = int'(l);
        lo = int'(LEN_MIN_L0);
        if (f == FMT_BE)
            lo = int'(LEN_MIN_L1);
        else if (f == FMT_LE32)
            lo = int'(LEN_MIN_L2);
        if (n < lo)
            n = lo;
        if (n > MAX_FRAME_BYTES)
            n = MAX_FRAME_BYTES;
        return n;
    endfunction

    function automatic int s16(logic [15:0] v);
        return int'($signed(v));
    endfunction

    function automatic logic [15:0] le_at(int i);
        return {cap[i+1], cap[i]};
    endfunction

    function automatic logic [15:0] be_at(int i);
        return {cap[i], cap[i+1]};
    endfunction

    function automatic int clamp_angle(int v);
        if (v > ANG_MAX)
            return ANG_MAX;
        if (v < ANG_MIN)
            return ANG_MIN;
        return v;
    endfunction

    function automatic int wrap_cdeg(int v);
        int r;
        r = v % TURN_CDEG;
        if (r < 0)
            r += TURN_CDEG;
        return r;
    endfunction

    task automatic apply_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] d);
        case (reg_index_t'(idx))
            REG_FRAME_FORMAT:   fmt_now = frame_fmt_t'(d[1:0]);
            REG_FRAME_LENGTH:   len_now = d[6:0];
            REG_PITCH_OFFSET:   pitch_trim = d[15:0];
            REG_ROLL_OFFSET:    roll_trim = d[15:0];
            REG_HEADING_OFFSET: heading_trim = d;
            default: ;
        endcase
    endtask

    task automatic decode_fields();
        int po;
        int ro;
        int ho;
        po = s16(pitch_trim);
        ro = s16(roll_trim);
        ho = int'($signed(heading_trim));
        if (fmt_now == FMT_BE)
        begin
            held_pitch = clamp_angle(s16(be_at(23)) + po);
            held_roll = clamp_angle(s16(be_at(25)) + ro);
            held_heading = wrap_cdeg(-s16(be_at(27)) + ho);
            if ((cap[11] & POS_FLAG) != 8'h00)
            begin
                held_lon = {be_at(12), be_at(14)};
                held_lat = {be_at(16), be_at(18)};
                held_stat = POS_STATUS;
            end
            return;
        end
        bad_run = 0;
        held_stat = cap[2];
        held_pitch = clamp_angle(-s16(le_at(9)) + po);
        held_roll = clamp_angle(-s16(le_at(11)) + ro);
        held_heading = wrap_cdeg(int'(le_at(13)) + ho);
        if (fmt_now == FMT_LE32)
        begin
            held_lon = {le_at(17), le_at(15)};
            held_lat = {le_at(21), le_at(19)};
            held_height = int'(le_at(23));
        end
        else
        begin
            held_lon = s16(le_at(15));
            held_lat = s16(le_at(17));
            held_height = s16(le_at(19));
        end
        held_rate_x = s16(le_at(5));
        held_rate_y = s16(le_at(3));
        held_rate_z = s16(le_at(7));
    endtask

    // Follows one accepted byte through the frame and queues the report
    // that the frame's last byte produces.
    task automatic track_frame_byte(logic [7:0] b, bit start);
        int last_idx;
        bit sum_bad;
        frame_report_t r;
        if (start)
        begin
            byte_idx = 0;
            sum_acc = '0;
            frame_closed = 1'b0;
        end
        if (frame_closed)
            return;
        live_bytes++;
        if (byte_idx < CAP_DEPTH)
            cap[byte_idx] = b;
        if (byte_idx == 0)
            hdr_ok = (b == HDR_BYTE0);
        else if (byte_idx == 1)
            hdr_ok = hdr_ok && (b == HDR_BYTE1);
        last_idx = frame_bytes(fmt_now, len_now) - 1;
        if (byte_idx < last_idx)
        begin
            sum_acc = sum_acc + b;
            byte_idx++;
            return;
        end
        frame_closed = 1'b1;
        if (fmt_now == FMT_BE)
            sum_bad = (sum_acc != b);
        else
            sum_bad = ((sum_acc + b) & 8'hFF) != 8'h00;
        if (!hdr_ok)
        begin
            r.code = RES_HEADER;
            if (bad_run < 65535)
                bad_run++;
        end
        else if (sum_bad)
        begin
            r.code = RES_CSUM;
            // A bad sum in the big-endian layout leaves the run alone.
            if (fmt_now != FMT_BE && bad_run < 65535)
                bad_run++;
        end
        else
        begin
            r.code = RES_OK;
            decode_fields();
        end
        r.status = held_stat;
        r.pitch = held_pitch[16:0];
        r.roll = held_roll[16:0];
        r.heading = held_heading[15:0];
        r.lon = held_lon;
        r.lat = held_lat;
        r.height = held_height[16:0];
        r.rate_x = held_rate_x[15:0];
        r.rate_y = held_rate_y[15:0];
        r.rate_z = held_rate_z[15:0];
        r.run = bad_run[15:0];
        reports_due.push_back(r);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%s mismatch: expected %0h, got %0h", what, want, got);
        end
    endtask

    task automatic check_report();
        frame_report_t want;
        if (reports_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("result word with none expected, code %0d", m_tuser);
            return;
        end
        want = reports_due.pop_front();
        check_field("result_code", want.code, m_tuser);
        check_field("unit_status", want.status, m_tdata[7:0]);
        check_field("pitch_cdeg", want.pitch, m_tdata[24:8]);
        check_field("roll_cdeg", want.roll, m_tdata[41:25]);
        check_field("heading_cdeg", want.heading, m_tdata[57:42]);
        check_field("longitude_raw", want.lon, m_tdata[89:58]);
        check_field("latitude_raw", want.lat, m_tdata[121:90]);
        check_field("height_m", want.height, m_tdata[138:122]);
        check_field("rate_x_raw", want.rate_x, m_tdata[154:139]);
        check_field("rate_y_raw", want.rate_y, m_tdata[170:155]);
        check_field("rate_z_raw", want.rate_z, m_tdata[186:171]);
        check_field("bad_frame_run", want.run, m_tdata[202:187]);
        last_code = m_tuser;
        last_run = m_tdata[202:187];
        reports_seen++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_report();
            if (cfg_we)
                apply_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                track_frame_byte(s_tdata, s_tuser);
        end
    end

    // Receiver: a long hold-off when asked for, random stalls otherwise.
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            m_tready <= 1'b0;
            recv_hold_left = recv_hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [7:0] b, bit start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the sender until every expected word is back, then lets the
    // block settle before anything else happens.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(reg_index_t idx, int v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_W'(v);
        @(negedge clk);
    endtask

    task automatic set_config(int f, int l, int p, int r, int h);
        put_reg(REG_FRAME_FORMAT, f);
        put_reg(REG_FRAME_LENGTH, l);
        put_reg(REG_PITCH_OFFSET, p);
        put_reg(REG_ROLL_OFFSET, r);
        put_reg(REG_HEADING_OFFSET, h);
        cfg_we <= 1'b0;
    endtask

    task automatic set_pace(int send_pct, int recv_pct, int hold);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        recv_hold_left = hold;
        @(negedge clk);
    endtask

    // Builds a well-formed frame of n bytes with a valid header and sum.
    task automatic fill_frame(int n, int fill, bit pos_flag);
        logic [7:0] acc;
        int i;
        acc = '0;
        for (i = 0; i < n; i++)
            frame_buf[i] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
        frame_buf[0] = HDR_BYTE0;
        frame_buf[1] = HDR_BYTE1;
        if (fmt_now == FMT_BE)
            frame_buf[11] = pos_flag ? (frame_buf[11] | POS_FLAG) : (frame_buf[11] & ~POS_FLAG);
        for (i = 0; i < n - 1; i++)
            acc = acc + frame_buf[i];
        frame_buf[n-1] = (fmt_now == FMT_BE) ? acc : 8'h00 - acc;
    endtask

    task automatic run_frame(frame_shape_t shape, int fill, bit pos_flag);
        int n;
        int k;
        int i;
        n = frame_bytes(fmt_now, len_now);
        // The cut frame is shorter than the programmed length; the length
        // drops under it just before its last byte, which then closes it.
        if (shape == SH_LEN_CUT)
            n = n - 9;
        fill_frame(n, fill, pos_flag);
        case (shape)
            SH_BAD_HEADER:
            begin
                k = $urandom_range(1);
                frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
            end
            SH_BAD_SUM:
            begin
                k = $urandom_range(2, n - 1);
                frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
            end
            SH_RESTART:
            begin
                k = $urandom_range(1, n - 1);
                for (i = 0; i < k; i++)
                    send_word(frame_buf[i], i == 0);
            end
            default: ;
        endcase
        if (shape == SH_LEN_CUT)
        begin
            for (i = 0; i < n - 1; i++)
                send_word(frame_buf[i], i == 0);
            quiesce();
            put_reg(REG_FRAME_LENGTH, LEN_MIN_L0);
            cfg_we <= 1'b0;
            send_word(frame_buf[n-1], 1'b0);
        end
        else
        begin
            for (i = 0; i < n; i++)
                send_word(frame_buf[i], (i == 0) && (shape != SH_NO_START));
        end
        if (shape == SH_TRAILING)
        begin
            k = $urandom_range(1, 6);
            for (i = 0; i < k; i++)
                send_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic shuffle_config();
        int f;
        int l;
        int p;
        int r;
        int h;
        int pick;
        f = $urandom_range(3);
        pick = $urandom_range(99);
        if (pick < 70)
            l = $urandom_range(21, 32);
        else if (pick < 85)
            l = $urandom_range(33, 64);
        else if (pick < 95)
            l = $urandom_range(0, 20);
        else
            l = $urandom_range(65, 127);
        if ($urandom_range(99) < 80)
            p = int'($urandom_range(36000)) - 18000;
        else
            p = $urandom_range(16'hFFFF);
        if ($urandom_range(99) < 80)
            r = int'($urandom_range(36000)) - 18000;
        else
            r = $urandom_range(16'hFFFF);
        if ($urandom_range(99) < 80)
            h = int'($urandom_range(72000)) - 36000;
        else
            h = $urandom_range(17'h1FFFF);
        set_config(f, l, p, r, h);
    endtask

    initial
    begin
        plan_row_t row;
        frame_shape_t shape;
        int i;
        int pick;
        int phase;
        int base_bytes;
        int base_reports;

        for (i = 0; i < CAP_DEPTH; i++)
            cap[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first row runs on the reset settings and without frame_start.
        for (i = 0; i < PLAN_ROWS; i++)
        begin
            row = plan[i];
            if (i > 0)
                set_config(row.fmt, row.len, row.pitch_adj, row.roll_adj, row.heading_adj);
            run_frame(row.shape, row.fill, row.pos_flag);
            quiesce();
            if (row.typed)
            begin
                check_field("planned result_code", row.code, last_code);
                check_field("planned bad_frame_run", row.run, last_run);
            end
        end

        base_bytes = live_bytes;
        base_reports = reports_seen;
        phase = 0;
        while ((live_bytes - base_bytes) < RANDOM_BYTES
               || (reports_seen - base_reports) < RANDOM_REPORTS
               || phase < 4)
        begin
            quiesce();
            shuffle_config();
            case (phase % 4)
                0: set_pace(0, 0, 300);
                1: set_pace(88, 0, 0);
                2: set_pace(0, 88, 0);
                default: set_pace(13, 13, 0);
            endcase
            repeat ($urandom_range(2, 4))
            begin
                pick = $urandom_range(99);
                if (pick < 72)
                    shape = SH_CLEAN;
                else if (pick < 80)
                    shape = SH_BAD_HEADER;
                else if (pick < 88)
                    shape = SH_BAD_SUM;
                else if (pick < 93)
                    shape = SH_RESTART;
                else if (pick < 97)
                    shape = SH_TRAILING;
                else
                    shape = SH_NO_START;
                run_frame(shape, ($urandom_range(99) < 90) ? -1 : $urandom_range(255),
                          $urandom_range(1));
            end
            phase++;
        end

        quiesce();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && reports_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ifd_pkg.sv
hw/rtl/inertial_frame_decoder.sv
test/inertial_frame_decoder_tb.sv
